[hdl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the wiep_checker module
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("property violated");

// next-cycle implication
`define ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("property violated");

`endif

[hdl/wiep_pkg.sv]
// ---------------------------------------------------------------------------
// wiep_pkg
// types, constants and helpers of the information element parser
// ---------------------------------------------------------------------------
package wiep_pkg;

  localparam int HEAD_DEPTH     = 20;
  localparam int HEAD_IDX_W     = $clog2(HEAD_DEPTH);
  localparam int POS_W          = 9;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] ID_HT   = 8'd45;
  localparam logic [7:0] ID_VHT  = 8'd191;
  localparam logic [7:0] ID_EXT  = 8'd255;
  localparam logic [7:0] EXT_HE  = 8'd35;
  localparam logic [7:0] EXT_EHT = 8'd108;

  localparam logic [7:0] LEN_HT  = 8'd7;
  localparam logic [7:0] LEN_VHT = 8'd6;
  localparam logic [7:0] LEN_EXT = 8'd1;
  localparam logic [7:0] LEN_HE  = 8'd20;
  localparam logic [7:0] LEN_EHT = 8'd12;

  localparam logic [13:0] FREQ_6G = 14'd5925;
  localparam logic [13:0] FREQ_5G = 14'd4900;

  localparam logic [2:0] GEN_LEGACY = 3'd3;
  localparam logic [2:0] GEN_N      = 3'd4;
  localparam logic [2:0] GEN_AC     = 3'd5;
  localparam logic [2:0] GEN_AX     = 3'd6;
  localparam logic [2:0] GEN_BE     = 3'd7;

  localparam logic [3:0] STREAMS_MIN = 4'd1;

  localparam logic [8:0] WIDTH_NONE = 9'd0;
  localparam logic [8:0] WIDTH_20   = 9'd20;
  localparam logic [8:0] WIDTH_40   = 9'd40;
  localparam logic [8:0] WIDTH_80   = 9'd80;
  localparam logic [8:0] WIDTH_160  = 9'd160;
  localparam logic [8:0] WIDTH_320  = 9'd320;

  typedef enum logic [1:0] {
    BAND_2G4 = 2'd0,
    BAND_5G  = 2'd1,
    BAND_6G  = 2'd2
  } band_t;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       cand;
    logic [2:0] gen;
    logic [3:0] streams;
    logic [8:0] width;
    band_t      band;
  } event_t;

  function automatic logic [3:0] map_streams(input logic [15:0] map);
    logic [3:0] n;
    n = '0;
    for (int s = 0; s < 8; s++) begin
      if (map[2*s +: 2] != 2'b11) begin
        n = 4'(s + 1);
      end
    end
    return n;
  endfunction

endpackage

[hdl/wiep_queue.sv]
// ---------------------------------------------------------------------------
// wiep_queue
// small register queue of parsed events between front and back
// ---------------------------------------------------------------------------
module wiep_queue #(
  parameter int DEPTH = wiep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  wiep_pkg::event_t push_data,
  output logic             full,
  input  logic             pop,
  output wiep_pkg::event_t head_data,
  output logic             empty
);
  import wiep_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  event_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hdl/wiep_front.sv]
// ---------------------------------------------------------------------------
// wiep_front
// element walker: tracks id, length and body head, classifies capabilities
// ---------------------------------------------------------------------------
module wiep_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ie_byte,
  input  logic             in_first_byte,
  input  logic             in_last_byte,
  input  logic [13:0]      in_freq_mhz,
  output logic             push,
  output wiep_pkg::event_t push_data,
  input  logic             queue_full
);
  import wiep_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [7:0]       len_r, len_nxt;
  band_t            band_r, band_nxt;
  logic [7:0]       head_r   [HEAD_DEPTH];
  logic [7:0]       head_nxt [HEAD_DEPTH];

  logic             accept;
  logic [POS_W-1:0] pos_cur;
  logic [POS_W-1:0] k;
  logic             done;
  logic             cand;
  logic [2:0]       cand_gen;
  logic [3:0]       cand_streams;
  logic [8:0]       cand_width;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign pos_cur  = in_first_byte ? '0 : pos_r;
  assign k        = pos_cur - POS_W'(2);

  always_comb begin
    band_nxt = band_r;
    if (in_first_byte) begin
      if (in_freq_mhz >= FREQ_6G) begin
        band_nxt = BAND_6G;
      end else if (in_freq_mhz >= FREQ_5G) begin
        band_nxt = BAND_5G;
      end else begin
        band_nxt = BAND_2G4;
      end
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    id_nxt   = id_r;
    len_nxt  = len_r;
    done     = 1'b0;
    head_nxt = head_r;
    if (pos_cur == POS_W'(0)) begin
      id_nxt  = in_ie_byte;
      pos_nxt = POS_W'(1);
    end else if (pos_cur == POS_W'(1)) begin
      len_nxt = in_ie_byte;
      pos_nxt = (in_ie_byte == 8'd0) ? '0 : POS_W'(2);
    end else begin
      if (k < POS_W'(HEAD_DEPTH)) begin
        head_nxt[k[HEAD_IDX_W-1:0]] = in_ie_byte;
      end
      done    = (pos_cur - POS_W'(1)) >= {1'b0, len_r};
      pos_nxt = done ? '0 : pos_cur + POS_W'(1);
    end
    if (in_last_byte) begin
      pos_nxt = '0;
    end
  end

  always_comb begin
    cand         = 1'b0;
    cand_gen     = GEN_LEGACY;
    cand_streams = '0;
    cand_width   = WIDTH_NONE;
    if (id_r == ID_HT && len_r >= LEN_HT) begin
      cand     = 1'b1;
      cand_gen = GEN_N;
      for (int s = 0; s < 4; s++) begin
        if (head_nxt[3 + s] != 8'd0) begin
          cand_streams = 4'(s + 1);
        end
      end
      cand_width = head_nxt[0][1] ? WIDTH_40 : WIDTH_20;
    end else if (id_r == ID_VHT && len_r >= LEN_VHT) begin
      cand         = 1'b1;
      cand_gen     = GEN_AC;
      cand_streams = map_streams({head_nxt[5], head_nxt[4]});
      cand_width   = (|head_nxt[0][3:2]) ? WIDTH_160 : WIDTH_80;
    end else if (id_r == ID_EXT && len_r >= LEN_EXT) begin
      if (head_nxt[0] == EXT_HE && len_r >= LEN_HE) begin
        cand         = 1'b1;
        cand_gen     = GEN_AX;
        cand_streams = map_streams({head_nxt[19], head_nxt[18]});
        if (band_nxt == BAND_2G4) begin
          cand_width = head_nxt[7][1] ? WIDTH_40 : WIDTH_20;
        end else if (head_nxt[7][3]) begin
          cand_width = WIDTH_160;
        end else if (head_nxt[7][2]) begin
          cand_width = WIDTH_80;
        end else begin
          cand_width = WIDTH_20;
        end
      end else if (head_nxt[0] == EXT_EHT && len_r >= LEN_EHT) begin
        cand       = 1'b1;
        cand_gen   = GEN_BE;
        cand_width = (band_nxt == BAND_6G && head_nxt[3][1]) ? WIDTH_320 : WIDTH_NONE;
      end
    end
  end

  assign push = accept && (in_first_byte || in_last_byte || (done && cand));

  always_comb begin
    push_data.first   = in_first_byte;
    push_data.last    = in_last_byte;
    push_data.cand    = done && cand;
    push_data.gen     = cand_gen;
    push_data.streams = cand_streams;
    push_data.width   = cand_width;
    push_data.band    = band_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      id_r   <= '0;
      len_r  <= '0;
      band_r <= BAND_2G4;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      id_r   <= id_nxt;
      len_r  <= len_nxt;
      band_r <= band_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_r <= head_nxt;
    end
  end

endmodule

[hdl/wiep_back.sv]
// ---------------------------------------------------------------------------
// wiep_back
// capability accumulator and result register
// ---------------------------------------------------------------------------
module wiep_back (
  input  logic             clk,
  input  logic             rst_n,
  input  wiep_pkg::event_t ev,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [2:0]       out_generation,
  output logic [3:0]       out_spatial_streams,
  output logic [8:0]       out_channel_width_mhz
);
  import wiep_pkg::*;

  logic [2:0] gen_r, gen_nxt;
  logic [3:0] streams_r, streams_nxt;
  logic [8:0] width_r, width_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_gen_r, out_gen_nxt;
  logic [3:0] out_streams_r, out_streams_nxt;
  logic [8:0] out_width_r, out_width_nxt;

  logic [2:0] base_gen, lift_gen;
  logic [3:0] base_streams, lift_streams;
  logic [8:0] base_width, lift_width;

  assign pop = !empty && (!ev.last || !out_valid_r || !out_stall);

  always_comb begin
    base_gen     = ev.first ? GEN_LEGACY : gen_r;
    base_streams = ev.first ? STREAMS_MIN : streams_r;
    base_width   = ev.first ? WIDTH_20 : width_r;
    lift_gen     = base_gen;
    lift_streams = base_streams;
    lift_width   = base_width;
    if (ev.cand) begin
      if (ev.gen > base_gen) begin
        lift_gen = ev.gen;
        if (ev.streams != 4'd0) begin
          lift_streams = ev.streams;
        end
      end else if (ev.gen == base_gen && ev.streams > base_streams) begin
        lift_streams = ev.streams;
      end
      if (ev.width > base_width) begin
        lift_width = ev.width;
      end
    end
  end

  always_comb begin
    gen_nxt         = gen_r;
    streams_nxt     = streams_r;
    width_nxt       = width_r;
    out_gen_nxt     = out_gen_r;
    out_streams_nxt = out_streams_r;
    out_width_nxt   = out_width_r;
    out_valid_nxt   = out_valid_r && out_stall;
    if (pop) begin
      if (ev.last) begin
        gen_nxt         = GEN_LEGACY;
        streams_nxt     = STREAMS_MIN;
        width_nxt       = WIDTH_20;
        out_valid_nxt   = 1'b1;
        out_gen_nxt     = (ev.band == BAND_2G4 && lift_gen == GEN_AC) ? GEN_N : lift_gen;
        out_streams_nxt = lift_streams;
        out_width_nxt   = lift_width;
      end else begin
        gen_nxt     = lift_gen;
        streams_nxt = lift_streams;
        width_nxt   = lift_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r       <= GEN_LEGACY;
      streams_r   <= STREAMS_MIN;
      width_r     <= WIDTH_20;
      out_valid_r <= 1'b0;
    end else begin
      gen_r       <= gen_nxt;
      streams_r   <= streams_nxt;
      width_r     <= width_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_gen_r     <= out_gen_nxt;
    out_streams_r <= out_streams_nxt;
    out_width_r   <= out_width_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_generation        = out_gen_r;
  assign out_spatial_streams   = out_streams_r;
  assign out_channel_width_mhz = out_width_r;

endmodule

[hdl/wifi_ie_capability_parser.sv]
// ---------------------------------------------------------------------------
// wifi_ie_capability_parser
// 802.11 information element list parser giving generation, streams, width
// ---------------------------------------------------------------------------
// takes one byte per cycle; the input stalls only when the event queue of
// QUEUE_DEPTH entries is full because the result side is stalled
// the event of the last byte passes through a queue entry and then the
// result register before the result is valid; a result-side stall can hold it
// synchronous active-low reset clears the walk, band, capabilities, queue
// and result valid
module wifi_ie_capability_parser #(
  parameter int QUEUE_DEPTH = wiep_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_ie_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [13:0] in_freq_mhz,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_generation,
  output logic [3:0]  out_spatial_streams,
  output logic [8:0]  out_channel_width_mhz
);
  import wiep_pkg::*;

  logic   push;
  event_t push_data;
  logic   queue_full;
  logic   pop;
  event_t head_data;
  logic   queue_empty;

  wiep_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_ie_byte    (in_ie_byte),
    .in_first_byte (in_first_byte),
    .in_last_byte  (in_last_byte),
    .in_freq_mhz   (in_freq_mhz),
    .push          (push),
    .push_data     (push_data),
    .queue_full    (queue_full)
  );

  wiep_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .head_data (head_data),
    .empty     (queue_empty)
  );

  wiep_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .ev                    (head_data),
    .empty                 (queue_empty),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation        (out_generation),
    .out_spatial_streams   (out_spatial_streams),
    .out_channel_width_mhz (out_channel_width_mhz)
  );

endmodule

[hdl/wiep_checker.sv]
// ---------------------------------------------------------------------------
// wiep_checker
// port-level checks on the parser result channel
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module wiep_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_generation,
  input logic [3:0] out_spatial_streams,
  input logic [8:0] out_channel_width_mhz
);
  import wiep_pkg::*;

  logic [15:0] out_payload;
  logic        range_ok;
  logic        width_ok;
  logic        legacy_ok;

  assign out_payload = {out_generation, out_spatial_streams, out_channel_width_mhz};
  assign range_ok    = out_generation >= GEN_LEGACY && out_spatial_streams >= STREAMS_MIN &&
                       out_spatial_streams <= 4'd8;
  assign width_ok    = out_channel_width_mhz inside
                       {WIDTH_20, WIDTH_40, WIDTH_80, WIDTH_160, WIDTH_320};
  assign legacy_ok   = out_channel_width_mhz == WIDTH_20 && out_spatial_streams == STREAMS_MIN;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_payload))
  `ASSERT_IMPL(a_gen_streams_range, clk, rst_n, out_valid, range_ok)
  `ASSERT_IMPL(a_width_legal, clk, rst_n, out_valid, width_ok)
  `ASSERT_IMPL(a_legacy_defaults, clk, rst_n, out_valid && out_generation == GEN_LEGACY, legacy_ok)

endmodule

bind wifi_ie_capability_parser wiep_checker u_checker (.*);

[bench/wifi_ie_capability_checker.sv]
// ---------------------------------------------------------------------------
// wifi_ie_capability_checker
// watches both channels of the information element parser, predicts the
// capability summary of every list and compares it field by field
// ---------------------------------------------------------------------------
module wifi_ie_capability_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_ie_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [13:0] in_freq_mhz,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_generation,
  input  logic [3:0]  out_spatial_streams,
  input  logic [8:0]  out_channel_width_mhz,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wiep_pkg::*;

  typedef struct packed {
    logic [2:0] gen;
    logic [3:0] streams;
    logic [8:0] width;
  } summary_t;

  logic [8:0] walk_pos;
  logic [7:0] elem_id;
  logic [7:0] elem_len;
  logic [7:0] body_head [HEAD_DEPTH];
  band_t      cur_band;
  logic [2:0] cap_gen;
  logic [3:0] cap_streams;
  logic [8:0] cap_width;
  summary_t   summary_q [$];

  initial begin
    fail_count = 0;
    pending_count = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [3:0] streams_in_map(input logic [15:0] map);
    for (int s = 7; s >= 0; s--) begin
      if (map[2*s +: 2] != 2'b11) begin
        return 4'(s + 1);
      end
    end
    return 4'd0;
  endfunction

  task automatic restart_caps();
    walk_pos = '0;
    elem_id = '0;
    elem_len = '0;
    cap_gen = GEN_LEGACY;
    cap_streams = STREAMS_MIN;
    cap_width = WIDTH_20;
  endtask

  task automatic merge_caps(input logic [2:0] g, input logic [3:0] st, input logic [8:0] w);
    if (g > cap_gen) begin
      cap_gen = g;
      if (st != 0) begin
        cap_streams = st;
      end
    end else if (g == cap_gen && st > cap_streams) begin
      cap_streams = st;
    end
    if (w > cap_width) begin
      cap_width = w;
    end
    if (cap_streams < STREAMS_MIN) begin
      cap_streams = STREAMS_MIN;
    end
  endtask

  task automatic finish_element();
    logic [3:0]  st;
    logic [8:0]  w;
    logic [15:0] map;
    if (elem_id == ID_HT && elem_len >= LEN_HT) begin
      st = '0;
      for (int s = 0; s < 4; s++) begin
        if (body_head[3 + s] != 8'd0) begin
          st = 4'(s + 1);
        end
      end
      merge_caps(GEN_N, st, body_head[0][1] ? WIDTH_40 : WIDTH_20);
    end else if (elem_id == ID_VHT && elem_len >= LEN_VHT) begin
      map = {body_head[5], body_head[4]};
      merge_caps(GEN_AC, streams_in_map(map),
                 (body_head[0][3:2] != 2'b00) ? WIDTH_160 : WIDTH_80);
    end else if (elem_id == ID_EXT && elem_len >= LEN_EXT) begin
      if (body_head[0] == EXT_HE && elem_len >= LEN_HE) begin
        map = {body_head[19], body_head[18]};
        if (cur_band == BAND_2G4) begin
          w = body_head[7][1] ? WIDTH_40 : WIDTH_20;
        end else begin
          w = body_head[7][3] ? WIDTH_160 : body_head[7][2] ? WIDTH_80 : WIDTH_20;
        end
        merge_caps(GEN_AX, streams_in_map(map), w);
      end else if (body_head[0] == EXT_EHT && elem_len >= LEN_EHT) begin
        merge_caps(GEN_BE, 4'd0,
                   (cur_band == BAND_6G && body_head[3][1]) ? WIDTH_320 : WIDTH_NONE);
      end
    end
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic first, input logic last,
                              input logic [13:0] freq);
    summary_t s;
    int       k;
    if (first) begin
      restart_caps();
      cur_band = (freq >= FREQ_6G) ? BAND_6G : (freq >= FREQ_5G) ? BAND_5G : BAND_2G4;
    end
    if (walk_pos == 9'd0) begin
      elem_id = b;
      walk_pos = 9'd1;
    end else if (walk_pos == 9'd1) begin
      elem_len = b;
      if (b == 8'd0) begin
        finish_element();
        walk_pos = 9'd0;
      end else begin
        walk_pos = 9'd2;
      end
    end else begin
      k = int'(walk_pos) - 2;
      if (k < HEAD_DEPTH) begin
        body_head[k] = b;
      end
      if (k + 1 >= int'(elem_len)) begin
        finish_element();
        walk_pos = 9'd0;
      end else begin
        walk_pos = walk_pos + 9'd1;
      end
    end
    if (last) begin
      s.gen = (cur_band == BAND_2G4 && cap_gen == GEN_AC) ? GEN_N : cap_gen;
      s.streams = cap_streams;
      s.width = cap_width;
      summary_q.push_back(s);
      restart_caps();
    end
  endtask

  always @(posedge clk) begin : watch_channels
    summary_t want;
    if (!rst_n) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        body_head[i] = 8'd0;
      end
      cur_band = BAND_2G4;
      restart_caps();
      summary_q.delete();
    end else begin
      if (in_valid && !in_stall) begin
        predict_byte(in_ie_byte, in_first_byte, in_last_byte, in_freq_mhz);
      end
      if (out_valid && !out_stall) begin
        if (summary_q.size() == 0) begin
          report_mismatch("summary with none pending, generation", out_generation, 0);
        end else begin
          want = summary_q.pop_front();
          if (out_generation !== want.gen) begin
            report_mismatch("generation", out_generation, want.gen);
          end
          if (out_spatial_streams !== want.streams) begin
            report_mismatch("spatial_streams", out_spatial_streams, want.streams);
          end
          if (out_channel_width_mhz !== want.width) begin
            report_mismatch("channel_width_mhz", out_channel_width_mhz, want.width);
          end
        end
      end
    end
    pending_count = summary_q.size();
  end

endmodule

[bench/wifi_ie_capability_parser_tb.sv]
// ---------------------------------------------------------------------------
// wifi_ie_capability_parser_tb
// feeds directed and random element lists to the parser under random idling
// and a long result-side hold, and gives the verdict from the checker
// ---------------------------------------------------------------------------
module wifi_ie_capability_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wiep_pkg::*;

  localparam int ITEMS_PER_PHASE = 700;
  localparam int HOLD_CYCLES     = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int DRAIN_CYCLES    = 16;

  typedef enum int {
    EL_HT, EL_VHT, EL_HE, EL_EHT, EL_EXT_OTHER, EL_OTHER, EL_EMPTY, EL_LONG
  } element_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_ie_byte;
  logic        in_first_byte;
  logic        in_last_byte;
  logic [13:0] in_freq_mhz;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_generation;
  logic [3:0]  out_spatial_streams;
  logic [8:0]  out_channel_width_mhz;
  int          mismatch_count;
  int          pending_results;

  int          send_idle_pct = 9;
  int          recv_idle_pct = 68;
  bit          hold_req = 1'b0;
  int          bytes_sent = 0;
  int          quiet_cycles = 0;
  logic [7:0]  list_bytes [$];

  wifi_ie_capability_parser uut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_ie_byte            (in_ie_byte),
    .in_first_byte         (in_first_byte),
    .in_last_byte          (in_last_byte),
    .in_freq_mhz           (in_freq_mhz),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation        (out_generation),
    .out_spatial_streams   (out_spatial_streams),
    .out_channel_width_mhz (out_channel_width_mhz)
  );

  wifi_ie_capability_checker capability_check (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_ie_byte            (in_ie_byte),
    .in_first_byte         (in_first_byte),
    .in_last_byte          (in_last_byte),
    .in_freq_mhz           (in_freq_mhz),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_generation        (out_generation),
    .out_spatial_streams   (out_spatial_streams),
    .out_channel_width_mhz (out_channel_width_mhz),
    .fail_count            (mismatch_count),
    .pending_count         (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side stall, with one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  function automatic logic [15:0] random_stream_map();
    logic [15:0] m;
    for (int s = 0; s < 8; s++) begin
      m[2*s +: 2] = ($urandom_range(1) == 1) ? 2'b11 : 2'($urandom_range(3));
    end
    return m;
  endfunction

  function automatic int pick_len(input int min_len);
    case ($urandom_range(3))
      0: return min_len - 1;
      3: return min_len + $urandom_range(1, 10);
      default: return min_len;
    endcase
  endfunction

  function automatic logic [7:0] pick_cap_id();
    case ($urandom_range(3))
      0: return ID_HT;
      1: return ID_VHT;
      2: return ID_EXT;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic element_kind_t pick_kind();
    if ($urandom_range(39) == 0) begin
      return EL_LONG;
    end
    return element_kind_t'($urandom_range(EL_EMPTY));
  endfunction

  function automatic logic [13:0] pick_freq();
    case ($urandom_range(9))
      0: return 14'd2412;
      1: return 14'd2484;
      2: return 14'd5180;
      3: return 14'd5955;
      4: return FREQ_5G - 14'd1;
      5: return FREQ_5G;
      6: return FREQ_6G - 14'd1;
      7: return FREQ_6G;
      8: return ($urandom_range(1) == 1) ? 14'h3FFF : 14'd0;
      default: return 14'($urandom_range(16383));
    endcase
  endfunction

  function automatic void add_element(input element_kind_t kind);
    logic [7:0]  id;
    int          len;
    logic [7:0]  body [$];
    logic [15:0] map;
    case (kind)
      EL_HT: begin
        id = ID_HT;
        len = pick_len(LEN_HT);
      end
      EL_VHT: begin
        id = ID_VHT;
        len = pick_len(LEN_VHT);
      end
      EL_HE: begin
        id = ID_EXT;
        len = pick_len(LEN_HE);
      end
      EL_EHT: begin
        id = ID_EXT;
        len = pick_len(LEN_EHT);
      end
      EL_EXT_OTHER: begin
        id = ID_EXT;
        len = $urandom_range(24);
      end
      EL_OTHER: begin
        id = 8'($urandom);
        len = $urandom_range(10);
      end
      EL_EMPTY: begin
        id = pick_cap_id();
        len = 0;
      end
      default: begin
        id = pick_cap_id();
        len = $urandom_range(200, 255);
      end
    endcase
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom));
    end
    map = random_stream_map();
    case (kind)
      EL_HT: begin
        for (int i = 3; i < 7 && i < len; i++) begin
          if ($urandom_range(1) == 1) begin
            body[i] = 8'd0;
          end
        end
      end
      EL_VHT: begin
        if (len > 5) begin
          body[4] = map[7:0];
          body[5] = map[15:8];
        end
      end
      EL_HE: begin
        body[0] = EXT_HE;
        if (len > 19) begin
          body[18] = map[7:0];
          body[19] = map[15:8];
        end
      end
      EL_EHT: begin
        body[0] = EXT_EHT;
      end
      EL_LONG: begin
        if (id == ID_EXT) begin
          body[0] = ($urandom_range(1) == 1) ? EXT_HE : EXT_EHT;
        end
      end
      default: begin
      end
    endcase
    list_bytes.push_back(id);
    list_bytes.push_back(8'(len));
    foreach (body[i]) begin
      list_bytes.push_back(body[i]);
    end
  endfunction

  // whole elements, sometimes followed by one cut off at the end
  function automatic void build_random_list();
    int base;
    int kept;
    list_bytes.delete();
    repeat ($urandom_range(1, 6)) add_element(pick_kind());
    if ($urandom_range(4) == 0) begin
      base = list_bytes.size();
      add_element(pick_kind());
      kept = $urandom_range(1, list_bytes.size() - base - 1);
      while (list_bytes.size() > base + kept) begin
        void'(list_bytes.pop_back());
      end
    end
  endfunction

  // starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [13:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_ie_byte <= b;
    in_first_byte <= first;
    in_last_byte <= last;
    in_freq_mhz <= freq;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_list(input logic [13:0] freq, input bit first_mark, input bit noisy);
    int n;
    int stray_first;
    int stray_last;
    n = list_bytes.size();
    stray_first = -1;
    stray_last = -1;
    if (noisy && n > 2 && $urandom_range(15) == 0) begin
      stray_first = $urandom_range(1, n - 2);
    end
    if (noisy && n > 2 && $urandom_range(19) == 0) begin
      stray_last = $urandom_range(1, n - 2);
    end
    for (int i = 0; i < n; i++) begin
      send_byte(list_bytes[i], (i == 0 && first_mark) || i == stray_first,
                i == n - 1 || i == stray_last,
                (i == 0 || i == stray_first) ? freq : 14'($urandom_range(16383)));
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_ie_byte <= 8'd0;
    in_first_byte <= 1'b0;
    in_last_byte <= 1'b0;
    in_freq_mhz <= 14'd0;
    rst_n <= 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // one-byte list, cut-off id only
    list_bytes = '{8'hFF};
    send_list(14'h3FFF, 1'b1, 1'b0);
    // ht on 2.4 GHz, four streams, 40 MHz
    list_bytes = '{ID_HT, 8'd7, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_list(14'd2412, 1'b1, 1'b0);
    // empty element, no first mark
    list_bytes = '{8'h00, 8'h00};
    send_list(14'd0, 1'b0, 1'b0);
    // vht on 2.4 GHz is reported as n
    list_bytes = '{ID_VHT, 8'd6, 8'h04, 8'h00, 8'h00, 8'h00, 8'hFE, 8'hFF};
    send_list(14'd2437, 1'b1, 1'b0);
    // vht cut off by the last byte
    list_bytes = '{ID_VHT, 8'd6, 8'h0C, 8'h00};
    send_list(14'd5180, 1'b1, 1'b0);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 9;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_req = 1'b1;
          repeat (12) begin
            list_bytes = '{8'($urandom)};
            send_list(pick_freq(), 1'b1, 1'b0);
          end
        end
      endcase
      while (bytes_sent < (ph + 1) * ITEMS_PER_PHASE) begin
        build_random_list();
        send_list(pick_freq(), $urandom_range(11) != 0, 1'b1);
      end
    end
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/wiep_pkg.sv
hdl/wiep_queue.sv
hdl/wiep_front.sv
hdl/wiep_back.sv
hdl/wifi_ie_capability_parser.sv
hdl/wiep_checker.sv
bench/wifi_ie_capability_checker.sv
bench/wifi_ie_capability_parser_tb.sv
